// ----- src/mbe_pkg.sv -----
// Shared types and constants for the Mandelbrot escape-time counter.
// No dependencies; imported by mandelbrot_escape_count.
package mbe_pkg;

  localparam int C_W           = 32;
  localparam int Z_W           = 36;
  localparam int COUNT_W       = 12;
  localparam int LIMIT_W       = 12;
  localparam int FRAC_BITS_DEF = 28;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

  typedef struct packed {
    logic signed [C_W-1:0] c_real;
    logic signed [C_W-1:0] c_imag;
  } point_t;

  typedef struct packed {
    logic [COUNT_W-1:0] iter_count;
    logic               escaped;
  } result_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SQR_RE = 6'b000010,
    S_SQR_IM = 6'b000100,
    S_CROSS  = 6'b001000,
    S_UPDATE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

endpackage

// ----- src/mandelbrot_escape_count.sv -----
// Mandelbrot escape-time counter: iterates z = z*z + c on one shared multiplier.
// Depends on mbe_pkg for the beat types, widths and sequencer states.
//
//   channel  direction  handshake        beat
//   in       input      in_valid/stall   point_t  (c_real, c_imag)
//   out      output     out_valid/stall  result_t (iter_count, escaped)
//   cfg      input      cfg_valid/ready  iteration_limit
//
// Each iteration forms three products through the one signed multiplier, in
// S_SQR_RE, S_SQR_IM and S_CROSS, then updates z in S_UPDATE. A point stops in
// S_CROSS when |z|^2 reaches 4.0 or the limit is met, or in S_SQR_RE when one
// component alone reaches 2.0; S_DONE loads its result and returns to S_IDLE.
// A result still held by out_stall keeps the sequencer waiting in its last state.
// Reset is synchronous and restores an iteration limit of 256.
// in_stall is high from the accepted beat until its result is loaded.
module mandelbrot_escape_count
  import mbe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  point_t             in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output result_t            out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data
);

  localparam int OPW  = FRAC_BITS + 2;
  localparam int PW   = 2 * OPW;
  localparam int EXTW = LIMIT_W + COUNT_W;

  localparam logic signed [Z_W-1:0] TWO  = Z_W'(2) <<< FRAC_BITS;
  localparam logic signed [Z_W-1:0] MTWO = -TWO;
  localparam logic signed [PW:0]    FOUR = (PW + 1)'(1) <<< (2 * FRAC_BITS + 2);
  localparam logic [COUNT_W-1:0]    CNT_MAX = '1;

  state_t                    state;
  logic [LIMIT_W-1:0]        iteration_limit;
  logic signed [C_W-1:0]     c_re;
  logic signed [C_W-1:0]     c_im;
  logic signed [Z_W-1:0]     zr;
  logic signed [Z_W-1:0]     zi;
  logic [COUNT_W-1:0]        count;
  logic                      esc;
  logic signed [PW-1:0]      sr;
  logic signed [PW-1:0]      si;
  logic signed [PW-1:0]      pri;

  logic signed [OPW-1:0]     op_a;
  logic signed [OPW-1:0]     op_b;
  logic signed [PW-1:0]      prod;
  logic signed [PW:0]        mag_sum;
  logic signed [PW:0]        diff;
  logic signed [PW:0]        cross2;
  logic signed [Z_W-1:0]     zr_next;
  logic signed [Z_W-1:0]     zi_next;
  logic [COUNT_W-1:0]        lim_eff;
  logic                      comp_big;
  logic                      stepped;

  always_comb begin
    unique case (state)
      S_SQR_RE: begin
        op_a = OPW'(zr);
        op_b = OPW'(zr);
      end
      S_SQR_IM: begin
        op_a = OPW'(zi);
        op_b = OPW'(zi);
      end
      default: begin
        op_a = OPW'(zr);
        op_b = OPW'(zi);
      end
    endcase
  end

  assign prod    = PW'(op_a) * PW'(op_b);
  assign mag_sum = (PW + 1)'(sr) + (PW + 1)'(si);
  assign diff    = (PW + 1)'(sr) - (PW + 1)'(si);
  assign cross2  = (PW + 1)'(pri) <<< 1;
  assign zr_next = Z_W'(diff >>> FRAC_BITS) + Z_W'(c_re);
  assign zi_next = Z_W'(cross2 >>> FRAC_BITS) + Z_W'(c_im);

  assign comp_big = (zr >= TWO) || (zr <= MTWO) || (zi >= TWO) || (zi <= MTWO);
  assign stepped  = (count != '0);
  assign lim_eff  = (EXTW'(iteration_limit) > EXTW'(CNT_MAX)) ? CNT_MAX
                                                               : COUNT_W'(iteration_limit);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      iteration_limit <= LIMIT_RESET;
      zr              <= '0;
      zi              <= '0;
      count           <= '0;
      esc             <= 1'b0;
    end else begin
      if (cfg_valid) begin
        iteration_limit <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            c_re  <= in_data.c_real;
            c_im  <= in_data.c_imag;
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            esc   <= 1'b0;
            state <= S_SQR_RE;
          end
        end
        S_SQR_RE: begin
          if (stepped && comp_big) begin
            esc   <= 1'b1;
            state <= S_DONE;
          end else begin
            sr    <= prod;
            state <= S_SQR_IM;
          end
        end
        S_SQR_IM: begin
          si    <= prod;
          state <= S_CROSS;
        end
        S_CROSS: begin
          pri <= prod;
          if (stepped && (mag_sum >= FOUR)) begin
            esc   <= 1'b1;
            state <= S_DONE;
          end else if (stepped && (count >= lim_eff)) begin
            state <= S_DONE;
          end else begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          zr    <= zr_next;
          zi    <= zi_next;
          count <= count + COUNT_W'(1);
          state <= S_SQR_RE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.iter_count <= count;
            out_data.escaped    <= esc;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A point that did not escape ran exactly to the effective limit, or one step when that limit is zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.escaped) |->
      ((out_data.iter_count == lim_eff) ||
       ((lim_eff == '0) && (out_data.iter_count == COUNT_W'(1)))))
    else $error("non-escaped count differs from the iteration limit");

  // No result exceeds the limit but a one-step result, and every result counts at least one step.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.iter_count != '0) &&
                   ((out_data.iter_count <= lim_eff) ||
                    (out_data.iter_count == COUNT_W'(1)))))
    else $error("result count outside one to the limit");

  // An accepted beat restarts the sequencer from z = 0.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=>
      ((state == S_SQR_RE) && (count == '0) && (zr == '0) && (zi == '0)))
    else $error("accepted beat did not restart the iteration");

endmodule
